>>> rtl/mjdr_pkg.sv
package mjdr_pkg;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_POS  = 2'd1,
      DIR_NEG  = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      MODE_REMOTE   = 2'd0,
      MODE_SOFTWARE = 2'd1,
      MODE_AUTO     = 2'd2,
      MODE_INVALID  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_JAM_TICKS     = 2'd0,
      REG_BACKOFF_TICKS = 2'd1,
      REG_OUTPUT_LIMIT  = 2'd2
   } reg_index_type;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int COUNT_WIDTH    = 16;
   localparam int LIMIT_WIDTH    = 15;
   localparam int DRIVE_WIDTH    = 16;

   localparam logic [COUNT_WIDTH-1:0] JAM_TICKS_RESET     = 16'd100;
   localparam logic [COUNT_WIDTH-1:0] BACKOFF_TICKS_RESET = 16'd50;
   localparam logic [LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET  = 15'd15000;

   // A stopped feeder stays stopped.
   function automatic logic [1:0] flip_dir(input logic [1:0] dir);
      logic [1:0] result;
      result = dir;
      case (dir)
         DIR_POS: result = DIR_NEG;
         DIR_NEG: result = DIR_POS;
         default: result = dir;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/motor_jam_detect_reverse.sv
// Channel   Ports                      Direction  Moves
// req       req_valid / req_ready      in         one control tick of command flags and drive
// rsp       rsp_valid / rsp_ready      out        direction and status after that tick
// csr       csr_psel ... csr_pready    in/out     jam_ticks, backoff_ticks, output_limit
//
// An input transfer loads the input register; once the result register can take it, the tick
// moves through the update logic into the result register, where the result is offered.
// With the result side ready, a new tick can be transferred in every cycle.
// Reset is synchronous; it clears the valid flags and restores the configuration and state.
// A stalled result holds the input register, which then holds req_ready low.
module motor_jam_detect_reverse (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_control_mode,
   input  logic                                 req_begin_positive,
   input  logic                                 req_begin_negative,
   input  logic                                 req_stop_request,
   input  logic                                 req_friction_on,
   input  logic                                 req_friction_off,
   input  logic signed [mjdr_pkg::DRIVE_WIDTH-1:0] req_drive_output,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_direction,
   output logic                                 rsp_friction_running,
   output logic                                 rsp_jammed,
   output logic                                 rsp_reversing,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mjdr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mjdr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mjdr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import mjdr_pkg::*;

   logic [COUNT_WIDTH-1:0] jam_ticks_ff;
   logic [COUNT_WIDTH-1:0] backoff_ticks_ff;
   logic [LIMIT_WIDTH-1:0] output_limit_ff;

   logic [COUNT_WIDTH-1:0] stall_count_ff, stall_count_in;
   logic [COUNT_WIDTH-1:0] reverse_count_ff, reverse_count_in;
   logic                   clearing_ff, clearing_in;
   logic [1:0]             feeder_dir_ff, feeder_dir_in;
   logic                   friction_ff, friction_in;
   logic                   prev_jam_ff, jam_in;

   logic                   s1_valid_ff;
   logic [1:0]             s1_mode_ff;
   logic                   s1_pos_ff, s1_neg_ff, s1_stop_ff, s1_fon_ff, s1_foff_ff;
   logic [DRIVE_WIDTH-1:0] s1_drive_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_direction_ff;
   logic                   rsp_friction_ff, rsp_jammed_ff, rsp_reversing_ff;

   logic                   rsp_load;
   logic                   csr_write;
   logic [1:0]             csr_index;
   logic [DRIVE_WIDTH-1:0] drive_mag;
   logic                   saturated;
   logic [1:0]             dir_cmd;
   logic [1:0]             dir_start;
   logic                   start_clear;
   logic                   clear_active;
   logic [COUNT_WIDTH-1:0] rc_base;
   logic [COUNT_WIDTH-1:0] rc_dec;

   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || rsp_load;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_JAM_TICKS:     csr_prdata = {{(CSR_DATA_WIDTH-COUNT_WIDTH){1'b0}}, jam_ticks_ff};
         REG_BACKOFF_TICKS: csr_prdata = {{(CSR_DATA_WIDTH-COUNT_WIDTH){1'b0}}, backoff_ticks_ff};
         REG_OUTPUT_LIMIT:  csr_prdata = {{(CSR_DATA_WIDTH-LIMIT_WIDTH){1'b0}}, output_limit_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jam_ticks_ff     <= JAM_TICKS_RESET;
         backoff_ticks_ff <= BACKOFF_TICKS_RESET;
         output_limit_ff  <= OUTPUT_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_JAM_TICKS:     jam_ticks_ff     <= csr_pwdata[COUNT_WIDTH-1:0];
            REG_BACKOFF_TICKS: backoff_ticks_ff <= csr_pwdata[COUNT_WIDTH-1:0];
            REG_OUTPUT_LIMIT:  output_limit_ff  <= csr_pwdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_mode_ff  <= req_control_mode;
         s1_pos_ff   <= req_begin_positive;
         s1_neg_ff   <= req_begin_negative;
         s1_stop_ff  <= req_stop_request;
         s1_fon_ff   <= req_friction_on;
         s1_foff_ff  <= req_friction_off;
         s1_drive_ff <= req_drive_output;
      end
   end

   always_comb begin
      dir_cmd     = feeder_dir_ff;
      friction_in = friction_ff;
      if (s1_mode_ff == MODE_REMOTE) begin
         if (s1_pos_ff && friction_ff) begin
            dir_cmd = DIR_POS;
         end
         if (s1_neg_ff && friction_ff) begin
            dir_cmd = DIR_NEG;
         end
         if (s1_stop_ff) begin
            dir_cmd = DIR_STOP;
         end
         if (s1_fon_ff) begin
            friction_in = 1'b1;
         end
         if (s1_foff_ff) begin
            friction_in = 1'b0;
         end
      end

      drive_mag = s1_drive_ff[DRIVE_WIDTH-1] ? (~s1_drive_ff + 1'b1) : s1_drive_ff;
      saturated = (drive_mag == {1'b0, output_limit_ff});

      if (saturated) begin
         stall_count_in = (stall_count_ff != '0) ? stall_count_ff - 1'b1 : '0;
      end else begin
         stall_count_in = jam_ticks_ff;
      end
      jam_in = (stall_count_in == '0);

      start_clear  = !prev_jam_ff && jam_in && !clearing_ff;
      clear_active = clearing_ff || start_clear;
      rc_base      = start_clear ? backoff_ticks_ff : reverse_count_ff;
      dir_start    = start_clear ? flip_dir(dir_cmd) : dir_cmd;
      rc_dec       = rc_base - 1'b1;

      feeder_dir_in    = dir_start;
      clearing_in      = clear_active;
      reverse_count_in = rc_base;
      if (clear_active) begin
         reverse_count_in = rc_dec;
         if (rc_dec == '0) begin
            feeder_dir_in    = flip_dir(dir_start);
            clearing_in      = 1'b0;
            reverse_count_in = backoff_ticks_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_count_ff   <= JAM_TICKS_RESET;
         reverse_count_ff <= BACKOFF_TICKS_RESET;
         clearing_ff      <= 1'b0;
         feeder_dir_ff    <= DIR_STOP;
         friction_ff      <= 1'b0;
         prev_jam_ff      <= 1'b0;
      end else if (rsp_load) begin
         stall_count_ff   <= stall_count_in;
         reverse_count_ff <= reverse_count_in;
         clearing_ff      <= clearing_in;
         feeder_dir_ff    <= feeder_dir_in;
         friction_ff      <= friction_in;
         prev_jam_ff      <= jam_in;
      end else if (csr_write && csr_index == REG_JAM_TICKS) begin
         stall_count_ff   <= csr_pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_direction_ff <= feeder_dir_in;
         rsp_friction_ff  <= friction_in;
         rsp_jammed_ff    <= jam_in;
         rsp_reversing_ff <= clearing_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_direction        = rsp_direction_ff;
   assign rsp_friction_running = rsp_friction_ff;
   assign rsp_jammed           = rsp_jammed_ff;
   assign rsp_reversing        = rsp_reversing_ff;

   // An active reversal always has ticks left to run.
   a_clear_count : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (reverse_count_ff != '0))
      else $error("reversal active with an empty countdown");

   // A held tick moves into the result register whenever that register can take it.
   a_advance : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("held tick did not produce a result");

   // A full input register behind a stalled result blocks new transfers.
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while the pipeline is full");

endmodule
